@@ src/jsu_pkg.sv @@
package jsu_pkg;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    localparam logic [3:0] ERR_NONE         = 4'd0;
    localparam logic [3:0] ERR_NO_OPEN      = 4'd1;
    localparam logic [3:0] ERR_CONTROL      = 4'd2;
    localparam logic [3:0] ERR_UNTERM       = 4'd3;
    localparam logic [3:0] ERR_UNTERM_ESC   = 4'd4;
    localparam logic [3:0] ERR_BAD_ESC      = 4'd5;
    localparam logic [3:0] ERR_HEX_SHORT    = 4'd6;
    localparam logic [3:0] ERR_BAD_HEX      = 4'd7;
    localparam logic [3:0] ERR_MISSING_LOW  = 4'd8;
    localparam logic [3:0] ERR_BAD_LOW      = 4'd9;
    localparam logic [3:0] ERR_LONE_LOW     = 4'd10;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one job per accepted input beat that yields results
    typedef struct packed {
        kind_t       kind;
        logic [3:0]  code;
        logic [20:0] cp;
        logic [1:0]  last_idx;   // utf-8 length minus one
    } job_t;

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp,
                                             input logic [1:0] last_idx,
                                             input logic [1:0] idx);
        logic [1:0] rem;
        logic [7:0] b;
        rem = last_idx - idx;
        b   = 8'h00;
        if (last_idx == 2'd0)
        begin
            b = cp[7:0];
        end
        else if (idx == 2'd0)
        begin
            case (last_idx)
                2'd1:    b = {3'b110, cp[10:6]};
                2'd2:    b = {4'b1110, cp[15:12]};
                default: b = {5'b11110, cp[20:18]};
            endcase
        end
        else
        begin
            case (rem)
                2'd0:    b = {2'b10, cp[5:0]};
                2'd1:    b = {2'b10, cp[11:6]};
                default: b = {2'b10, cp[17:12]};
            endcase
        end
        return b;
    endfunction

endpackage

@@ src/jsu_front.sv @@
module jsu_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    in_byte,
    input  logic          input_end,
    input  logic          q_full,
    output logic          q_push,
    output jsu_pkg::job_t q_job
);
    import jsu_pkg::*;

    typedef enum logic [7:0] {
        PH_IDLE   = 8'b0000_0001,
        PH_WAIT   = 8'b0000_0010,
        PH_STR    = 8'b0000_0100,
        PH_ESC    = 8'b0000_1000,
        PH_HEX1   = 8'b0001_0000,
        PH_LOW_BS = 8'b0010_0000,
        PH_LOW_U  = 8'b0100_0000,
        PH_HEX2   = 8'b1000_0000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [15:0] acc_reg, acc_next;
    logic [9:0]  hi_reg, hi_next;

    logic        accept;
    logic [4:0]  digit;
    logic [15:0] hex_val;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        case (in_byte) inside
            [8'h30:8'h39]: digit = {1'b0, in_byte[3:0]};
            [8'h41:8'h46],
            [8'h61:8'h66]: digit = {1'b0, in_byte[3:0] + 4'd9};
            default:       digit = 5'h10;
        endcase
    end

    assign hex_val = {acc_reg[11:0], digit[3:0]};

    function automatic logic [1:0] utf8_last(input logic [20:0] cp);
        if (cp <= 21'h7F)
            return 2'd0;
        else if (cp <= 21'h7FF)
            return 2'd1;
        else if (cp <= 21'hFFFF)
            return 2'd2;
        return 2'd3;
    endfunction

    always_comb
    begin
        logic       err;
        logic [3:0] code;
        logic       emit;
        job_t       j;
        err        = 1'b0;
        code       = ERR_NONE;
        emit       = 1'b0;
        j.kind     = KIND_DATA;
        j.code     = ERR_NONE;
        j.cp       = '0;
        j.last_idx = 2'd0;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        hi_next    = hi_reg;

        case (phase_reg)
            PH_IDLE:
            begin
                if (!input_end)
                begin
                    if (in_byte == 8'h22)
                        phase_next = PH_STR;
                    else
                    begin
                        err  = 1'b1;
                        code = ERR_NO_OPEN;
                    end
                end
            end
            PH_WAIT:
            begin
                if (!input_end && in_byte == 8'h22)
                    phase_next = PH_STR;
            end
            PH_STR:
            begin
                if (input_end)
                begin
                    err  = 1'b1;
                    code = ERR_UNTERM;
                end
                else if (in_byte == 8'h22)
                begin
                    phase_next = PH_IDLE;
                    emit       = 1'b1;
                    j.kind     = KIND_CLOSE;
                end
                else if (in_byte < 8'h20)
                begin
                    err  = 1'b1;
                    code = ERR_CONTROL;
                end
                else if (in_byte == 8'h5C)
                    phase_next = PH_ESC;
                else
                begin
                    emit = 1'b1;
                    j.cp = {13'd0, in_byte};
                end
            end
            PH_ESC:
            begin
                if (input_end)
                begin
                    err  = 1'b1;
                    code = ERR_UNTERM_ESC;
                end
                else
                begin
                    phase_next = PH_STR;
                    emit       = 1'b1;
                    case (in_byte)
                        8'h22, 8'h5C, 8'h2F: j.cp = {13'd0, in_byte};
                        8'h62: j.cp = 21'h08;
                        8'h66: j.cp = 21'h0C;
                        8'h6E: j.cp = 21'h0A;
                        8'h72: j.cp = 21'h0D;
                        8'h74: j.cp = 21'h09;
                        8'h75:
                        begin
                            emit       = 1'b0;
                            phase_next = PH_HEX1;
                            cnt_next   = 2'd0;
                            acc_next   = 16'd0;
                        end
                        default:
                        begin
                            emit = 1'b0;
                            err  = 1'b1;
                            code = ERR_BAD_ESC;
                        end
                    endcase
                end
            end
            PH_HEX1, PH_HEX2:
            begin
                if (input_end)
                begin
                    err  = 1'b1;
                    code = ERR_HEX_SHORT;
                end
                else if (digit[4])
                begin
                    err  = 1'b1;
                    code = ERR_BAD_HEX;
                end
                else
                begin
                    acc_next = hex_val;
                    if (cnt_reg != 2'd3)
                        cnt_next = cnt_reg + 2'd1;
                    else
                    begin
                        cnt_next = 2'd0;
                        if (phase_reg == PH_HEX1)
                        begin
                            if (hex_val[15:10] == 6'b110110)
                            begin
                                hi_next    = hex_val[9:0];
                                phase_next = PH_LOW_BS;
                            end
                            else if (hex_val[15:10] == 6'b110111)
                            begin
                                err  = 1'b1;
                                code = ERR_LONE_LOW;
                            end
                            else
                            begin
                                phase_next = PH_STR;
                                emit       = 1'b1;
                                j.cp       = {5'd0, hex_val};
                                j.last_idx = utf8_last(j.cp);
                            end
                        end
                        else
                        begin
                            if (hex_val[15:10] != 6'b110111)
                            begin
                                err  = 1'b1;
                                code = ERR_BAD_LOW;
                            end
                            else
                            begin
                                phase_next = PH_STR;
                                emit       = 1'b1;
                                j.cp       = 21'h10000 + {1'b0, hi_reg, hex_val[9:0]};
                                j.last_idx = 2'd3;
                            end
                        end
                    end
                end
            end
            PH_LOW_BS:
            begin
                if (!input_end && in_byte == 8'h5C)
                    phase_next = PH_LOW_U;
                else
                begin
                    err  = 1'b1;
                    code = ERR_MISSING_LOW;
                end
            end
            PH_LOW_U:
            begin
                if (!input_end && in_byte == 8'h75)
                begin
                    phase_next = PH_HEX2;
                    cnt_next   = 2'd0;
                    acc_next   = 16'd0;
                end
                else
                begin
                    err  = 1'b1;
                    code = ERR_MISSING_LOW;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (err)
        begin
            phase_next = PH_WAIT;
            emit       = 1'b1;
            j.kind     = KIND_ERROR;
            j.code     = code;
            j.cp       = '0;
            j.last_idx = 2'd0;
        end

        q_push = accept && emit;
        q_job  = j;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= 2'd0;
            acc_reg   <= 16'd0;
            hi_reg    <= 10'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            hi_reg    <= hi_next;
        end
    end

endmodule

@@ src/jsu_queue.sv @@
module jsu_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  jsu_pkg::job_t push_job,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output jsu_pkg::job_t head_job
);
    import jsu_pkg::*;

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign head_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("pop from empty queue");
`endif

endmodule

@@ src/jsu_back.sv @@
module jsu_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  jsu_pkg::job_t head_job,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    out_byte,
    output logic [1:0]    out_kind,
    output logic [3:0]    error_code,
    output logic          last_of_run
);
    import jsu_pkg::*;

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic [1:0] kind_reg;
    logic [3:0] code_reg;
    logic       last_reg;
    logic [1:0] idx_reg, idx_next;

    logic       load;
    logic       take;
    logic       job_last;
    logic [7:0] beat_byte;

    assign load      = !valid_reg || !out_stall;
    assign take      = load && !q_empty;
    assign job_last  = (head_job.kind != KIND_DATA) || (idx_reg == head_job.last_idx);
    assign q_pop     = take && job_last;
    assign idx_next  = job_last ? 2'd0 : idx_reg + 2'd1;
    assign beat_byte = (head_job.kind == KIND_DATA)
                       ? utf8_byte(head_job.cp, head_job.last_idx, idx_reg) : 8'h00;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (load)
        begin
            valid_reg <= !q_empty;
            if (take)
                idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= beat_byte;
            kind_reg <= head_job.kind;
            code_reg <= (head_job.kind == KIND_ERROR) ? head_job.code : ERR_NONE;
            last_reg <= job_last;
        end
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign out_kind    = kind_reg;
    assign error_code  = code_reg;
    assign last_of_run = last_reg;

`ifndef SYNTH
    a_single_beat_nondata: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_kind != KIND_DATA) |-> last_of_run)
        else $error("close or error beat not last of run");
    a_error_has_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_kind == KIND_ERROR) |-> (error_code != ERR_NONE))
        else $error("error beat without code");
    a_idx_resets_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (idx_reg == 2'd0))
        else $error("byte index not cleared after job");
`endif

endmodule

@@ src/json_string_unescape_utf8_unit.sv @@
// JSON string unescaper: raw text bytes in, decoded UTF-8 bytes out.
// Input channel: in_valid/in_stall with in_byte and input_end; a beat is taken
// when in_valid is high and in_stall is low. Feed the text from its opening
// quote; input_end marks the end of input and carries no byte.
// Output channel: out_valid/out_stall with out_byte, out_kind (data, close,
// error), error_code and last_of_run, which flags the final beat caused by
// one input beat. After an error the unit skips bytes up to the next quote.
// Timing: while the queue is not full the front decoder takes one input beat
// per cycle, writing at most one job into a 4-entry queue; the back end turns
// each job into 1 to 4 output beats, one per cycle while out_stall is low,
// through a registered output stage, which each job reaches via the queue.
// Input throughput is one beat per cycle while each beat yields at most one
// output byte and out_stall is low; the queue absorbs multi-byte \u results.
// When the receiver stalls the output beat holds; the queue fills and then
// in_stall rises, with no loss. Reset (rst_n low, asynchronous) empties the
// queue and output stage and returns the decoder to expecting an opening quote.
module json_string_unescape_utf8_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       input_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [1:0] out_kind,
    output logic [3:0] error_code,
    output logic       last_of_run
);
    import jsu_pkg::*;

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    job_t push_job;
    job_t head_job;

    jsu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .input_end (input_end),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    jsu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head_job (head_job)
    );

    jsu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .head_job    (head_job),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .out_kind    (out_kind),
        .error_code  (error_code),
        .last_of_run (last_of_run)
    );

endmodule

@@ dv/json_string_unescape_utf8_unit_tb.sv @@
module json_string_unescape_utf8_unit_tb;
    import jsu_pkg::*;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    typedef enum logic [2:0] {
        DEC_IDLE,
        DEC_WAIT,
        DEC_STR,
        DEC_ESC,
        DEC_HEX1,
        DEC_LOW_BS,
        DEC_LOW_U,
        DEC_HEX2
    } dec_phase_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic [3:0] code;
        logic       last;
    } out_beat_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       input_end;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic [3:0] error_code;
    logic       last_of_run;

    json_string_unescape_utf8_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .input_end   (input_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .out_kind    (out_kind),
        .error_code  (error_code),
        .last_of_run (last_of_run)
    );

    // decoder shadow state
    dec_phase_t  dec_phase = DEC_IDLE;
    logic [1:0]  hex_count = 2'd0;
    logic [15:0] hex_acc   = 16'd0;
    logic [9:0]  high_bits = 10'd0;

    out_beat_t   expected_beats[$];
    out_beat_t   run_beats[$];
    logic [7:0]  text_buf[$];
    out_beat_t   seen_beat;
    out_beat_t   due_beat;

    int mismatches   = 0;
    int beats_sent   = 0;
    int burst_left   = 0;
    bit gaps_on      = 1'b1;
    int stall_hold   = 0;
    int stall_mode   = 0;
    int stall_left   = 0;
    int stall_tick   = 0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic void add_beat(logic [7:0] d, kind_t k, logic [3:0] c);
        out_beat_t b;
        b.data = d;
        b.kind = k;
        b.code = c;
        b.last = 1'b0;
        run_beats.insert(run_beats.size(), b);
    endfunction

    function automatic void add_data(logic [7:0] d);
        add_beat(d, KIND_DATA, ERR_NONE);
    endfunction

    function automatic void add_error(logic [3:0] c);
        dec_phase = DEC_WAIT;
        add_beat(8'h00, KIND_ERROR, c);
    endfunction

    function automatic void add_utf8(logic [20:0] cp);
        if (cp < 21'h80)
        begin
            add_data(cp[7:0]);
        end
        else if (cp < 21'h800)
        begin
            add_data({3'b110, cp[10:6]});
            add_data({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000)
        begin
            add_data({4'b1110, cp[15:12]});
            add_data({2'b10, cp[11:6]});
            add_data({2'b10, cp[5:0]});
        end
        else
        begin
            add_data({5'b11110, cp[20:18]});
            add_data({2'b10, cp[17:12]});
            add_data({2'b10, cp[11:6]});
            add_data({2'b10, cp[5:0]});
        end
    endfunction

    // bit 4 set: not a hex digit
    function automatic logic [4:0] hex_digit_value(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return {1'b0, c[3:0]};
        if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            return {1'b0, c[3:0] + 4'd9};
        return 5'h10;
    endfunction

    function automatic void predict_beat(logic [7:0] c, logic e);
        logic [4:0]  d;
        logic [15:0] v;
        run_beats.delete();
        case (dec_phase)
            DEC_IDLE:
            begin
                if (!e)
                begin
                    if (c == CH_QUOTE)
                        dec_phase = DEC_STR;
                    else
                        add_error(ERR_NO_OPEN);
                end
            end
            DEC_WAIT:
            begin
                if (!e && c == CH_QUOTE)
                    dec_phase = DEC_STR;
            end
            DEC_STR:
            begin
                if (e)
                    add_error(ERR_UNTERM);
                else if (c == CH_QUOTE)
                begin
                    dec_phase = DEC_IDLE;
                    add_beat(8'h00, KIND_CLOSE, ERR_NONE);
                end
                else if (c < 8'h20)
                    add_error(ERR_CONTROL);
                else if (c == CH_BSLASH)
                    dec_phase = DEC_ESC;
                else
                    add_data(c);
            end
            DEC_ESC:
            begin
                if (e)
                    add_error(ERR_UNTERM_ESC);
                else
                begin
                    dec_phase = DEC_STR;
                    case (c)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: add_data(c);
                        CH_B: add_data(8'h08);
                        CH_F: add_data(8'h0C);
                        CH_N: add_data(8'h0A);
                        CH_R: add_data(8'h0D);
                        CH_T: add_data(8'h09);
                        CH_U:
                        begin
                            dec_phase = DEC_HEX1;
                            hex_count = 2'd0;
                            hex_acc   = 16'd0;
                        end
                        default: add_error(ERR_BAD_ESC);
                    endcase
                end
            end
            DEC_HEX1, DEC_HEX2:
            begin
                d = hex_digit_value(c);
                if (e)
                    add_error(ERR_HEX_SHORT);
                else if (d[4])
                    add_error(ERR_BAD_HEX);
                else
                begin
                    v = {hex_acc[11:0], d[3:0]};
                    hex_acc = v;
                    if (hex_count != 2'd3)
                        hex_count = hex_count + 2'd1;
                    else
                    begin
                        hex_count = 2'd0;
                        if (dec_phase == DEC_HEX1)
                        begin
                            if (v >= 16'hD800 && v <= 16'hDBFF)
                            begin
                                high_bits = v[9:0];
                                dec_phase = DEC_LOW_BS;
                            end
                            else if (v >= 16'hDC00 && v <= 16'hDFFF)
                                add_error(ERR_LONE_LOW);
                            else
                            begin
                                dec_phase = DEC_STR;
                                add_utf8({5'd0, v});
                            end
                        end
                        else
                        begin
                            if (v < 16'hDC00 || v > 16'hDFFF)
                                add_error(ERR_BAD_LOW);
                            else
                            begin
                                dec_phase = DEC_STR;
                                add_utf8(21'h10000 + {high_bits, v[9:0]});
                            end
                        end
                    end
                end
            end
            DEC_LOW_BS:
            begin
                if (!e && c == CH_BSLASH)
                    dec_phase = DEC_LOW_U;
                else
                    add_error(ERR_MISSING_LOW);
            end
            default:
            begin
                if (!e && c == CH_U)
                begin
                    dec_phase = DEC_HEX2;
                    hex_count = 2'd0;
                    hex_acc   = 16'd0;
                end
                else
                    add_error(ERR_MISSING_LOW);
            end
        endcase
        if (run_beats.size() > 0)
            run_beats[run_beats.size() - 1].last = 1'b1;
        foreach (run_beats[i])
            expected_beats.insert(expected_beats.size(), run_beats[i]);
    endfunction

    // caller sits at a rising edge
    task automatic send_beat(input logic [7:0] b, input logic e);
        int gap;
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 12);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left--;
        end
        in_valid  <= 1'b1;
        in_byte   <= b;
        input_end <= e;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_beat(b, e);
        beats_sent++;
    endtask

    task automatic send_end();
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b0);
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_all_results();
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + n;
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
    endfunction

    function automatic void add_text(logic [7:0] b);
        text_buf.insert(text_buf.size(), b);
    endfunction

    function automatic void push_hex_escape(logic [15:0] v);
        add_text(CH_BSLASH);
        add_text(CH_U);
        add_text(hex_char(v[15:12]));
        add_text(hex_char(v[11:8]));
        add_text(hex_char(v[7:4]));
        add_text(hex_char(v[3:0]));
    endfunction

    function automatic void push_segment();
        logic [7:0]  b;
        logic [15:0] v;
        int          pick;
        pick = $urandom_range(0, 9);
        if (pick <= 3)
        begin
            do
                b = 8'($urandom_range(8'h20, 8'hFF));
            while (b == CH_QUOTE || b == CH_BSLASH);
            add_text(b);
        end
        else if (pick <= 5)
        begin
            add_text(CH_BSLASH);
            case ($urandom_range(0, 7))
                0: add_text(CH_QUOTE);
                1: add_text(CH_BSLASH);
                2: add_text(CH_SLASH);
                3: add_text(CH_B);
                4: add_text(CH_F);
                5: add_text(CH_N);
                6: add_text(CH_R);
                default: add_text(CH_T);
            endcase
        end
        else if (pick == 6)
            push_hex_escape(16'($urandom_range(0, 16'h07FF)));
        else if (pick == 7)
        begin
            v = 16'($urandom_range(16'h0800, 16'hFFFF));
            if (v >= 16'hD800 && v <= 16'hDFFF)
                v = v ^ 16'h4000;
            push_hex_escape(v);
        end
        else
        begin
            push_hex_escape(16'hD800 + 16'($urandom_range(0, 16'h3FF)));
            push_hex_escape(16'hDC00 + 16'($urandom_range(0, 16'h3FF)));
        end
    endfunction

    // receiver stall pattern plus a counted long hold-off
    always @(posedge clk)
    begin
        if (stall_hold > 0)
        begin
            out_stall <= 1'b1;
            stall_hold--;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 80);
            end
            stall_left--;
            stall_tick++;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 99) < 30);
                2: out_stall <= (stall_tick % 5 == 3);
                default: out_stall <= ($urandom_range(0, 99) < 70);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_beat.data = out_byte;
            seen_beat.kind = kind_t'(out_kind);
            seen_beat.code = error_code;
            seen_beat.last = last_of_run;
            if (expected_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected beat byte %02h kind %0d code %0d last %0d",
                             $time, seen_beat.data, seen_beat.kind, seen_beat.code,
                             seen_beat.last);
            end
            else
            begin
                due_beat = expected_beats.pop_front();
                if (seen_beat.data !== due_beat.data || seen_beat.kind !== due_beat.kind ||
                    seen_beat.code !== due_beat.code || seen_beat.last !== due_beat.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: expected byte %02h kind %0d code %0d last %0d,",
                                  " got %02h %0d %0d %0d"},
                                 $time, due_beat.data, due_beat.kind, due_beat.code,
                                 due_beat.last, seen_beat.data, seen_beat.kind,
                                 seen_beat.code, seen_beat.last);
                end
            end
        end
    end

    task automatic test_plain_and_escapes();
        gaps_on = 1'b1;
        send_text("\" ");
        send_beat(8'h7F, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_text("\\\"\\\\\\/\\b\\f\\n\\r\\t\"");
        stop_sending();
    endtask

    task automatic test_unicode();
        send_text("\"\\u0000\\u07fF\\uFFFF\\uDBFF\\uDFFF\\uD800\\udc00\"");
        stop_sending();
    endtask

    task automatic test_errors();
        send_text("xy");
        send_end();
        send_text("\"");
        send_beat(8'h1F, 1'b0);
        send_text("\"\"");
        send_end();
        send_text("\"a");
        send_end();
        send_text("\"\\");
        send_end();
        send_text("\"\\q");
        send_text("\"\\u12");
        send_end();
        send_text("\"\\u1g");
        send_text("\"\\u12\"");
        send_text("\"\\uD800x");
        send_text("\"\\uD800\"");
        send_text("\"\\uD800\\x");
        send_text("\"\\ud800\\uE000");
        send_text("\"\\uDBFF\\uDBFF");
        send_text("\"\\uDC00");
        send_text("\"\\uD800");
        send_end();
        send_text("\"\\uD800\\");
        send_end();
        send_text("\"\\uD800\\u12");
        send_end();
        send_text("\"ok\"");
        stop_sending();
    endtask

    task automatic test_backpressure();
        gaps_on = 1'b0;
        wait_all_results();
        stall_hold = 60;
        send_text("\"\\uDBFF\\uDFFFab\\uD800\\uDC00\\uFFFFcdefgh\\u07FF\\uD83D\\uDE00\"");
        stop_sending();
        wait_all_results();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_strings();
        int  start;
        int  corrupt_at;
        int  n;
        bit  paused;
        start  = beats_sent;
        paused = 1'b0;
        while (beats_sent - start < 120)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                    send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
            else
            begin
                text_buf.delete();
                add_text(CH_QUOTE);
                n = $urandom_range(1, 5);
                repeat (n)
                    push_segment();
                add_text(CH_QUOTE);
                corrupt_at = ($urandom_range(0, 4) == 0) ?
                             $urandom_range(1, text_buf.size() - 1) : -1;
                foreach (text_buf[i])
                begin
                    if (i == corrupt_at)
                    begin
                        if ($urandom_range(0, 2) == 0)
                            send_end();
                        else
                            send_beat(8'($urandom_range(0, 255)), 1'b0);
                    end
                    send_beat(text_buf[i], 1'b0);
                end
            end
            if (!paused && beats_sent - start >= 60)
            begin
                paused = 1'b1;
                stop_sending();
                wait_all_results();
            end
        end
        stop_sending();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_byte   = 8'h00;
        input_end = 1'b0;
        out_stall = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_and_escapes();
        test_unicode();
        test_errors();
        test_backpressure();
        test_random_strings();

        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (expected_beats.size() != 0)
        begin
            mismatches++;
            $display("%0d expected beats never arrived", expected_beats.size());
        end
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
